// ===== hw/rtl/l4pf_pkg.sv =====
// ----------------------------------------------------------------------------
// l4pf_pkg
// shared constants and types of the l4 port filter and redirect block
// ----------------------------------------------------------------------------
package l4pf_pkg;

  localparam int QUEUE_COUNT_DEF = 256;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [6:0]  ETH_HDR_LEN    = 7'd14;
  localparam logic [3:0]  IHL_MASK       = 4'hF;
  localparam logic [5:0]  IP_MIN_HDR     = 6'd20;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [6:0]  L4_PORT_BYTES  = 7'd4;
  localparam logic [6:0]  ETYPE_POS_HI   = 7'd12;
  localparam logic [6:0]  ETYPE_POS_LO   = 7'd13;
  localparam logic [6:0]  PROTO_OFS      = 7'd9;
  localparam logic [6:0]  BYTE_CNT_MAX   = 7'd127;

  // port bitmap: {udp, port} key, stored as rows of 64 bits
  localparam int KEY_W      = 17;
  localparam int ROW_BIT_W  = 6;
  localparam int ROW_BITS   = 1 << ROW_BIT_W;
  localparam int ROW_ADDR_W = KEY_W - ROW_BIT_W;
  localparam int PM_ROWS    = 1 << ROW_ADDR_W;

  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  typedef enum logic [1:0] {
    MODE_FRAME    = 2'd0,
    MODE_PORT_WR  = 2'd1,
    MODE_QUEUE_WR = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    RSN_CAPTURED  = 3'd0,
    RSN_TOO_SHORT = 3'd1,
    RSN_NOT_IPV4  = 3'd2,
    RSN_BAD_IHL   = 3'd3,
    RSN_NOT_L4    = 3'd4,
    RSN_NO_MATCH  = 3'd5,
    RSN_NO_SOCKET = 3'd6
  } reason_t;

  typedef enum logic [1:0] {
    SIDE_NONE = 2'd0,
    SIDE_DST  = 2'd1,
    SIDE_SRC  = 2'd2
  } side_t;

  typedef struct packed {
    side_t       side;
    reason_t     reason;
    logic [7:0]  queue;
    logic        verdict;
  } result_t;

endpackage

// ===== hw/rtl/l4_port_filter_redirect_top.sv =====
// ----------------------------------------------------------------------------
// l4_port_filter_redirect_top
// ipv4 tcp/udp port match classifier with per-queue redirect
//
// The in_ channel carries one beat per cycle while in_tready is high: frame bytes (tuser mode frame,
// tlast on the final byte), port filter writes and queue socket writes. The
// out_ channel carries one verdict beat per frame.
// Frame parsing runs in flip-flops. The port bitmap sits in a 2048 x 64
// memory with two read ports, read when the last byte is taken; filter
// writes are read-modify-write of one row, forwarded to a read that lands
// on the write cycle. The socket bits sit in a 256 x 1 memory with valid
// bits that reset clears.
// Throughput is one beat per cycle while in_tready is high. The memory reads
// for a last byte share its accepting edge with the second stage registers;
// the row check follows there and its verdict goes into the result queue.
// After reset a clearing pass writes zeros to all 2048 bitmap rows, one per
// cycle; in_tready stays low until the pass ends.
// A four-entry result queue lets input continue while out_tready is low;
// in_tready drops only once the queue and the result in flight fill it.
// ----------------------------------------------------------------------------
module l4_port_filter_redirect_top #(
  parameter int QUEUE_COUNT = l4pf_pkg::QUEUE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // data_byte[7:0], queue_index[15:8], key_is_udp[16], key_port[32:17],
  // entry_present[33], zero fill[39:34]
  input  logic [39:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // verdict[0], out_queue[8:1], reason[11:9], matched_side[13:12],
  // zero fill[15:14]
  output logic [15:0] out_tdata
);
  import l4pf_pkg::*;

  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  // input decode
  mode_t        in_mode;
  logic [7:0]   in_byte;
  logic [7:0]   in_q;
  logic [KEY_W-1:0] in_key;
  logic         in_present;
  logic         acc;
  logic         is_frame;
  logic         is_last;
  logic         is_pwr;
  logic         is_qwr;
  logic         q_ok;
  logic [QW-1:0] qi;

  assign in_mode    = mode_t'(in_tuser);
  assign in_byte    = in_tdata[7:0];
  assign in_q       = in_tdata[15:8];
  assign in_key     = {in_tdata[16], in_tdata[32:17]};
  assign in_present = in_tdata[33];
  assign acc        = in_tvalid && in_tready;
  assign is_frame   = acc && (in_mode == MODE_FRAME);
  assign is_last    = is_frame && in_tlast;
  assign is_pwr     = acc && (in_mode == MODE_PORT_WR);
  assign is_qwr     = acc && (in_mode == MODE_QUEUE_WR);
  assign q_ok       = 32'(in_q) < QUEUE_COUNT;
  assign qi         = QW'(in_q);

  // clearing pass
  logic                  clearing_r;
  logic [ROW_ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ROW_ADDR_W'(PM_ROWS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // frame parse state
  logic [6:0]  cnt_r, cnt_nxt;
  logic [5:0]  ihl_r, ihl_nxt;
  reason_t     status_r, status_nxt;
  logic        udp_r, udp_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [6:0]  l4;
  logic [6:0]  k_ofs;
  logic        lookup;
  reason_t     pre_reason;

  always_comb begin
    cnt_nxt    = (cnt_r == BYTE_CNT_MAX) ? cnt_r : cnt_r + 7'd1;
    ihl_nxt    = ihl_r;
    status_nxt = status_r;
    udp_nxt    = udp_r;
    sport_nxt  = sport_r;
    dport_nxt  = dport_r;
    l4         = ETH_HDR_LEN + {1'b0, ihl_r};
    k_ofs      = cnt_r - l4;
    if (cnt_r == ETYPE_POS_HI) begin
      sport_nxt = {8'h00, in_byte};
    end else if (cnt_r == ETYPE_POS_LO) begin
      if ({sport_r[7:0], in_byte} != ETHERTYPE_IPV4 && status_r == RSN_CAPTURED) begin
        status_nxt = RSN_NOT_IPV4;
      end
    end else if (cnt_r == ETH_HDR_LEN) begin
      ihl_nxt = {in_byte[3:0] & IHL_MASK, 2'b00};
      if (ihl_nxt < IP_MIN_HDR && status_r == RSN_CAPTURED) begin
        status_nxt = RSN_BAD_IHL;
      end
    end else if (cnt_r == ETH_HDR_LEN + PROTO_OFS) begin
      udp_nxt = (in_byte == PROTO_UDP);
      if (in_byte != PROTO_TCP && in_byte != PROTO_UDP && status_r == RSN_CAPTURED) begin
        status_nxt = RSN_NOT_L4;
      end
    end
    // port bytes, using the header length as updated by this byte
    if (ihl_nxt >= IP_MIN_HDR && cnt_r >= l4 && cnt_r < l4 + L4_PORT_BYTES) begin
      unique case (k_ofs[1:0])
        2'd0:    sport_nxt = {in_byte, 8'h00};
        2'd1:    sport_nxt = {sport_r[15:8], in_byte};
        2'd2:    dport_nxt = {in_byte, 8'h00};
        default: dport_nxt = {dport_r[15:8], in_byte};
      endcase
    end
  end

  always_comb begin
    lookup     = 1'b0;
    pre_reason = RSN_TOO_SHORT;
    priority if (cnt_nxt < ETH_HDR_LEN) begin
      pre_reason = RSN_TOO_SHORT;
    end else if (status_nxt == RSN_NOT_IPV4) begin
      pre_reason = RSN_NOT_IPV4;
    end else if (cnt_nxt < ETH_HDR_LEN + 7'(IP_MIN_HDR)) begin
      pre_reason = RSN_TOO_SHORT;
    end else if (status_nxt == RSN_BAD_IHL) begin
      pre_reason = RSN_BAD_IHL;
    end else if (status_nxt == RSN_NOT_L4) begin
      pre_reason = RSN_NOT_L4;
    end else if (cnt_nxt < ETH_HDR_LEN + {1'b0, ihl_nxt} + L4_PORT_BYTES) begin
      pre_reason = RSN_TOO_SHORT;
    end else begin
      lookup = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ihl_r    <= '0;
      status_r <= RSN_CAPTURED;
      udp_r    <= 1'b0;
      sport_r  <= '0;
      dport_r  <= '0;
    end else if (is_frame) begin
      if (in_tlast) begin
        cnt_r    <= '0;
        ihl_r    <= '0;
        status_r <= RSN_CAPTURED;
        udp_r    <= 1'b0;
        sport_r  <= '0;
        dport_r  <= '0;
      end else begin
        cnt_r    <= cnt_nxt;
        ihl_r    <= ihl_nxt;
        status_r <= status_nxt;
        udp_r    <= udp_nxt;
        sport_r  <= sport_nxt;
        dport_r  <= dport_nxt;
      end
    end
  end

  // port bitmap memory
  logic [ROW_BITS-1:0]   pm_mem [PM_ROWS];
  logic [ROW_BITS-1:0]   pm_rd_a_r, pm_rd_b_r;
  logic [KEY_W-1:0]      key_a, key_b;
  logic                  pm_we;
  logic [ROW_ADDR_W-1:0] pm_waddr;
  logic [ROW_BITS-1:0]   pm_wdata;

  assign key_a = is_pwr ? in_key : {udp_nxt, dport_nxt};
  assign key_b = {udp_nxt, sport_nxt};

  always_ff @(posedge clk) begin
    pm_rd_a_r <= pm_mem[key_a[KEY_W-1:ROW_BIT_W]];
    pm_rd_b_r <= pm_mem[key_b[KEY_W-1:ROW_BIT_W]];
    if (pm_we) begin
      pm_mem[pm_waddr] <= pm_wdata;
    end
  end

  // queue socket memory with valid bits
  logic           qs_mem [QUEUE_COUNT];
  logic           qs_vld_r [QUEUE_COUNT];
  logic           qs_rd_r;
  logic           qs_ok_r;

  always_ff @(posedge clk) begin
    if (is_qwr && q_ok) begin
      qs_mem[qi] <= in_present;
    end
    if (q_ok) begin
      qs_rd_r <= qs_mem[qi];
    end
    qs_ok_r <= q_ok && qs_vld_r[qi];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        qs_vld_r[i] <= 1'b0;
      end
    end else if (is_qwr && q_ok) begin
      qs_vld_r[qi] <= 1'b1;
    end
  end

  // second stage: row check, filter write back
  logic                  s2_vld_r;
  logic                  s2_res_r;
  logic                  s2_lookup_r;
  reason_t               s2_reason_r;
  logic [7:0]            s2_q_r;
  logic [ROW_ADDR_W-1:0] s2_row_a_r, s2_row_b_r;
  logic [ROW_BIT_W-1:0]  s2_bit_a_r, s2_bit_b_r;
  logic                  s2_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s2_res_r <= 1'b0;
    end else begin
      s2_vld_r <= is_last || is_pwr;
      s2_res_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    s2_lookup_r  <= lookup;
    s2_reason_r  <= pre_reason;
    s2_q_r       <= in_q;
    s2_row_a_r   <= key_a[KEY_W-1:ROW_BIT_W];
    s2_row_b_r   <= key_b[KEY_W-1:ROW_BIT_W];
    s2_bit_a_r   <= key_a[ROW_BIT_W-1:0];
    s2_bit_b_r   <= key_b[ROW_BIT_W-1:0];
    s2_present_r <= in_present;
  end

  // forwarding of the write that shares the read edge
  logic                  fwd_vld_r;
  logic [ROW_ADDR_W-1:0] fwd_row_r;
  logic [ROW_BITS-1:0]   fwd_data_r;
  logic [ROW_BITS-1:0]   row_a, row_b, new_row;
  logic                  s2_wr;
  result_t               s2_result;
  logic                  dhit, shit;

  assign s2_wr = s2_vld_r && !s2_res_r;

  always_comb begin
    row_a = (fwd_vld_r && fwd_row_r == s2_row_a_r) ? fwd_data_r : pm_rd_a_r;
    row_b = (fwd_vld_r && fwd_row_r == s2_row_b_r) ? fwd_data_r : pm_rd_b_r;
    new_row = row_a;
    new_row[s2_bit_a_r] = s2_present_r;
    dhit = row_a[s2_bit_a_r];
    shit = row_b[s2_bit_b_r];
    s2_result.queue   = s2_q_r;
    s2_result.verdict = 1'b0;
    s2_result.side    = SIDE_NONE;
    s2_result.reason  = s2_reason_r;
    if (s2_lookup_r) begin
      priority if (dhit) begin
        s2_result.side = SIDE_DST;
      end else if (shit) begin
        s2_result.side = SIDE_SRC;
      end else begin
        s2_result.side = SIDE_NONE;
      end
      priority if (!dhit && !shit) begin
        s2_result.reason = RSN_NO_MATCH;
      end else if (qs_ok_r && qs_rd_r) begin
        s2_result.reason  = RSN_CAPTURED;
        s2_result.verdict = 1'b1;
      end else begin
        s2_result.reason = RSN_NO_SOCKET;
      end
    end
  end

  assign pm_we    = clearing_r || s2_wr;
  assign pm_waddr = clearing_r ? clr_addr_r : s2_row_a_r;
  assign pm_wdata = clearing_r ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else begin
      fwd_vld_r <= s2_wr;
    end
  end

  always_ff @(posedge clk) begin
    fwd_row_r  <= s2_row_a_r;
    fwd_data_r <= new_row;
  end

  // result queue
  result_t            fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   fifo_cnt_r;
  logic               push, pop;

  assign push       = s2_vld_r && s2_res_r;
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = {2'b00, fifo_mem[rd_ptr_r]};
  assign in_tready  = !clearing_r &&
                      ((fifo_cnt_r + {{FIFO_AW{1'b0}}, push}) < (FIFO_AW + 1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= s2_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};
    end
  end

  // assertions
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready)
    else $error("beat accepted during clearing pass");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clearing_r |=> !clearing_r)
    else $error("clearing pass restarted");

  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_cnt_r < (FIFO_AW + 1)'(FIFO_DEPTH) || pop))
    else $error("result queue overflow");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_last |=> (s2_vld_r && s2_res_r))
    else $error("last byte did not reach the check stage");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_pwr |=> (s2_vld_r && !s2_res_r))
    else $error("filter write lost or produced a result");

endmodule

// ===== test/l4_port_filter_redirect_top_tb.sv =====
// ----------------------------------------------------------------------------
// l4_port_filter_redirect_top_tb
// self-checking testbench for the l4 port filter and redirect block
//
// Frame bytes, port filter writes, queue socket writes and unused-mode beats
// are queued up front and sent by a clocked driver with random gaps. A
// monitor on the rising edge classifies every accepted input beat with its
// own model of the parser, the port bitmap and the socket bits, and compares
// each verdict beat field by field with the oldest expected verdict. The
// receiver stalls at random and twice holds off long enough to back up the
// block and stall its input.
// ----------------------------------------------------------------------------
module l4_port_filter_redirect_top_tb;
  import l4pf_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int WATCHDOG_LIMIT       = 10000;
  localparam int DRAIN_CYCLES         = 20;
  localparam int HOLD_CYCLES          = 600;
  localparam int MAX_REPORTS          = 10;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  data;
    logic        last;
    logic [7:0]  queue;
    logic        key_udp;
    logic [15:0] key_port;
    logic        present;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  beat_t   pending_beats [$];
  result_t expected_verdicts [$];

  // model state
  bit          port_hits [131072];
  bit          queue_sockets [256];
  int          byte_cnt;
  logic [5:0]  ip_hlen;
  bit          fault_seen;
  reason_t     hdr_fault;
  bit          udp_flag;
  logic [15:0] src_port;
  logic [15:0] dst_port;

  logic  in_beat_done = 1'b0;
  beat_t tx_beat;
  beat_t taken_beat;
  int    tx_gap;
  bit    tx_steady;
  int    rx_gap;
  bit    rx_steady;
  int    hold_left;
  int    holds_done;
  int    results_seen;
  int    mismatches;
  int    idle_cycles;
  int    n_frames;

  l4_port_filter_redirect_top #(
    .QUEUE_COUNT(QUEUE_COUNT_DEF)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [15:0] pick_port();
    if ($urandom_range(99) < 40) return 16'($urandom);
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd65535;
      2: return 16'd80;
      3: return 16'd443;
      4: return 16'd53;
      5: return 16'd8080;
      6: return 16'd1;
      default: return 16'd32768;
    endcase
  endfunction

  function automatic logic [7:0] pick_queue();
    if ($urandom_range(99) < 30) return 8'($urandom);
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      default: return 8'd255;
    endcase
  endfunction

  task automatic push_beat(input logic [1:0] mode, input logic [7:0] data, input logic last,
                           input logic [7:0] queue, input logic udp, input logic [15:0] port,
                           input logic present);
    beat_t b;
    b.mode     = mode;
    b.data     = data;
    b.last     = last;
    b.queue    = queue;
    b.key_udp  = udp;
    b.key_port = port;
    b.present  = present;
    pending_beats.push_back(b);
  endtask

  task automatic push_table_write();
    int r;
    r = $urandom_range(99);
    if (r < 55)
      push_beat(MODE_PORT_WR, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                pick_port(), $urandom_range(9) < 7);
    else if (r < 90)
      push_beat(MODE_QUEUE_WR, 8'($urandom), 1'($urandom), pick_queue(), 1'($urandom),
                16'($urandom), $urandom_range(9) < 6);
    else
      push_beat(MODE_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                16'($urandom), 1'($urandom));
  endtask

  task automatic push_random_frame();
    logic [7:0]  fb [$];
    int          kind;
    int          ihl;
    int          hdr_bytes;
    int          len;
    int          r;
    logic [15:0] etype;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [7:0]  q;
    kind = $urandom_range(99);
    if (kind >= 70 && kind < 80) ihl = $urandom_range(4);
    else ihl = ($urandom_range(9) < 7) ? 5 : $urandom_range(15, 6);
    hdr_bytes = (ihl < 5) ? int'(IP_MIN_HDR) : ihl * 4;
    etype = ETHERTYPE_IPV4;
    if (kind >= 60 && kind < 70) begin
      etype = 16'($urandom);
      if ($urandom_range(1)) etype = ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(15));
      if (etype == ETHERTYPE_IPV4) etype = 16'h86DD;
    end
    proto = $urandom_range(1) ? PROTO_UDP : PROTO_TCP;
    if (kind >= 80 && kind < 90) begin
      proto = 8'($urandom);
      if ($urandom_range(1)) proto = $urandom_range(1) ? PROTO_UDP + 8'd1 : PROTO_TCP - 8'd1;
      if (proto == PROTO_TCP || proto == PROTO_UDP) proto = PROTO_TCP + 8'd1;
    end
    sport = pick_port();
    dport = pick_port();
    repeat (12) fb.push_back(8'($urandom));
    fb.push_back(etype[15:8]);
    fb.push_back(etype[7:0]);
    fb.push_back({4'($urandom), 4'(ihl)});
    for (int i = 1; i < hdr_bytes; i++) fb.push_back((i == PROTO_OFS) ? proto : 8'($urandom));
    fb.push_back(sport[15:8]);
    fb.push_back(sport[7:0]);
    fb.push_back(dport[15:8]);
    fb.push_back(dport[7:0]);
    r = $urandom_range(99);
    if (r < 60) len = 0;
    else if (r < 90) len = $urandom_range(20, 1);
    else if (r < 98) len = $urandom_range(60, 21);
    else len = $urandom_range(120, 80);
    repeat (len) fb.push_back(8'($urandom));
    len = fb.size();
    if (kind >= 45 && kind < 60) begin
      len = $urandom_range(len - 1, 1);
    end else if (kind >= 90) begin
      len = $urandom_range(20, 1);
      for (int i = 0; i < len; i++) fb[i] = 8'($urandom);
    end
    q = pick_queue();
    for (int i = 0; i < len; i++) begin
      // table writes and unused beats inside a frame must not disturb it
      if ($urandom_range(99) < 3) push_table_write();
      push_beat(MODE_FRAME, fb[i], i == len - 1, (i == len - 1) ? q : 8'($urandom),
                1'($urandom), 16'($urandom), 1'($urandom));
    end
    n_frames++;
  endtask

  task automatic classify_beat(input beat_t b);
    int      pos;
    int      l4;
    int      n;
    result_t r;
    case (b.mode)
      MODE_PORT_WR: port_hits[{b.key_udp, b.key_port}] = b.present;
      MODE_QUEUE_WR: if (b.queue < QUEUE_COUNT_DEF) queue_sockets[b.queue] = b.present;
      MODE_FRAME: begin
        pos = byte_cnt;
        l4 = ETH_HDR_LEN + ip_hlen;
        if (pos == ETYPE_POS_HI) begin
          src_port = {8'd0, b.data};
        end else if (pos == ETYPE_POS_LO) begin
          if ({src_port[7:0], b.data} != ETHERTYPE_IPV4 && !fault_seen) begin
            fault_seen = 1'b1;
            hdr_fault = RSN_NOT_IPV4;
          end
        end else if (pos == ETH_HDR_LEN) begin
          ip_hlen = {b.data[3:0] & IHL_MASK, 2'b00};
          if (ip_hlen < IP_MIN_HDR && !fault_seen) begin
            fault_seen = 1'b1;
            hdr_fault = RSN_BAD_IHL;
          end
        end else if (pos == ETH_HDR_LEN + PROTO_OFS) begin
          udp_flag = (b.data == PROTO_UDP);
          if (b.data != PROTO_TCP && b.data != PROTO_UDP && !fault_seen) begin
            fault_seen = 1'b1;
            hdr_fault = RSN_NOT_L4;
          end
        end
        // old offset, new header length: matches the hardware on the ihl byte
        if (ip_hlen >= IP_MIN_HDR && pos >= l4 && pos < l4 + L4_PORT_BYTES) begin
          case (pos - l4)
            0: src_port = {b.data, 8'd0};
            1: src_port[7:0] = b.data;
            2: dst_port = {b.data, 8'd0};
            default: dst_port[7:0] = b.data;
          endcase
        end
        if (byte_cnt < BYTE_CNT_MAX) byte_cnt++;
        if (b.last) begin
          n = byte_cnt;
          r.verdict = 1'b0;
          r.queue = b.queue;
          r.side = SIDE_NONE;
          if (n < ETH_HDR_LEN) r.reason = RSN_TOO_SHORT;
          else if (fault_seen && hdr_fault == RSN_NOT_IPV4) r.reason = RSN_NOT_IPV4;
          else if (n < ETH_HDR_LEN + IP_MIN_HDR) r.reason = RSN_TOO_SHORT;
          else if (fault_seen) r.reason = hdr_fault;
          else if (n < ETH_HDR_LEN + ip_hlen + L4_PORT_BYTES) r.reason = RSN_TOO_SHORT;
          else begin
            if (port_hits[{udp_flag, dst_port}]) r.side = SIDE_DST;
            else if (port_hits[{udp_flag, src_port}]) r.side = SIDE_SRC;
            if (r.side == SIDE_NONE) begin
              r.reason = RSN_NO_MATCH;
            end else if (b.queue < QUEUE_COUNT_DEF && queue_sockets[b.queue]) begin
              r.reason = RSN_CAPTURED;
              r.verdict = 1'b1;
            end else begin
              r.reason = RSN_NO_SOCKET;
            end
          end
          expected_verdicts.push_back(r);
          byte_cnt = 0;
          ip_hlen = '0;
          fault_seen = 1'b0;
          udp_flag = 1'b0;
          src_port = '0;
          dst_port = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_beat_done) begin
      // hold the beat until it is taken
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_tvalid <= 1'b0;
    end else if (pending_beats.size() > 0) begin
      tx_beat = pending_beats.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= {6'd0, tx_beat.present, tx_beat.key_port, tx_beat.key_udp, tx_beat.queue,
                    tx_beat.data};
      in_tuser  <= tx_beat.mode;
      in_tlast  <= tx_beat.last;
      tx_gap = pick_gap(tx_steady);
      if ($urandom_range(299) == 0) tx_steady = !tx_steady;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if ((holds_done == 0 && results_seen >= 15) ||
                 (holds_done == 1 && results_seen >= 60)) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_gap = pick_gap(rx_steady);
      if ($urandom_range(299) == 0) rx_steady = !rx_steady;
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    result_t exp_v;
    result_t got_v;
    in_beat_done <= in_tvalid && in_tready;
    if (rst_n) begin
      idle_cycles++;
      if (in_tvalid && in_tready) begin
        taken_beat.mode     = in_tuser;
        taken_beat.data     = in_tdata[7:0];
        taken_beat.queue    = in_tdata[15:8];
        taken_beat.key_udp  = in_tdata[16];
        taken_beat.key_port = in_tdata[32:17];
        taken_beat.present  = in_tdata[33];
        taken_beat.last     = in_tlast;
        classify_beat(taken_beat);
        idle_cycles = 0;
      end
      if (out_tvalid && out_tready) begin
        got_v = result_t'(out_tdata[13:0]);
        results_seen++;
        idle_cycles = 0;
        if (expected_verdicts.size() == 0) begin
          note_mismatch($sformatf("unexpected verdict beat %h", out_tdata));
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (got_v.verdict !== exp_v.verdict || got_v.queue !== exp_v.queue ||
              got_v.reason !== exp_v.reason || got_v.side !== exp_v.side)
            note_mismatch($sformatf(
              "verdict %0d exp %0d, queue %0d exp %0d, reason %0d exp %0d, side %0d exp %0d",
              got_v.verdict, exp_v.verdict, got_v.queue, exp_v.queue,
              got_v.reason, exp_v.reason, got_v.side, exp_v.side));
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    // directed: table extremes, unused mode, a one-byte frame, a non-ipv4 frame
    push_beat(MODE_PORT_WR, 8'h00, 1'b0, 8'h00, 1'b0, 16'd80, 1'b1);
    push_beat(MODE_PORT_WR, 8'hFF, 1'b1, 8'hFF, 1'b1, 16'hFFFF, 1'b1);
    push_beat(MODE_PORT_WR, 8'h00, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b1);
    push_beat(MODE_PORT_WR, 8'h00, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);
    push_beat(MODE_QUEUE_WR, 8'h00, 1'b0, 8'hFF, 1'b0, 16'h0000, 1'b1);
    push_beat(MODE_QUEUE_WR, 8'hFF, 1'b1, 8'h00, 1'b1, 16'hFFFF, 1'b1);
    push_beat(MODE_QUEUE_WR, 8'h00, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0);
    push_beat(MODE_QUEUE_WR, 8'h00, 1'b0, 8'h01, 1'b0, 16'h0000, 1'b1);
    push_beat(MODE_UNUSED, 8'hFF, 1'b1, 8'hFF, 1'b1, 16'hFFFF, 1'b1);
    push_beat(MODE_FRAME, 8'hFF, 1'b1, 8'hFF, 1'b1, 16'hFFFF, 1'b1);
    for (int i = 0; i < 14; i++) begin
      if (i == 7) push_beat(MODE_QUEUE_WR, 8'h00, 1'b0, 8'h02, 1'b0, 16'h0000, 1'b1);
      push_beat(MODE_FRAME, (i == 12) ? 8'h86 : (i == 13) ? 8'hDD : 8'(i), i == 13,
                (i == 13) ? 8'h00 : 8'($urandom), 1'b0, 16'h0000, 1'b0);
    end
    repeat (12) push_table_write();
    while (pending_beats.size() < 1900 || n_frames < 80) begin
      push_random_frame();
      if ($urandom_range(99) < 35) repeat ($urandom_range(3, 1)) push_table_write();
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/l4pf_pkg.sv
hw/rtl/l4_port_filter_redirect_top.sv
test/l4_port_filter_redirect_top_tb.sv
